[rtl/core/efrc16_pkg.sv]
// Package with the phase type, status codes, reset values and CRC-16 byte update for the deframer.
`default_nettype none

package efrc16_pkg;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_START = 3'd1,
    PH_LEN   = 3'd2,
    PH_DATA  = 3'd3,
    PH_CRCH  = 3'd4,
    PH_CRCL  = 3'd5,
    PH_ESC   = 3'd6
  } phase_t;

  localparam logic [1:0] ST_NONE = 2'd0;
  localparam logic [1:0] ST_DATA = 2'd1;
  localparam logic [1:0] ST_GOOD = 2'd2;
  localparam logic [1:0] ST_BAD  = 2'd3;

  localparam logic [0:0] CFG_START_BYTE  = 1'b0;
  localparam logic [0:0] CFG_ESCAPE_BYTE = 1'b1;

  localparam logic [7:0]  START_BYTE_RST  = 8'hEE;
  localparam logic [7:0]  ESCAPE_BYTE_RST = 8'h30;
  localparam logic [15:0] CRC_INIT        = 16'hFFFF;
  localparam logic [15:0] CRC_POLY        = 16'hA001;

  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/core/escaped_frame_receiver_crc16.sv]
// Top level of the byte-stuffed frame receiver with CRC-16 check.
// The input channel takes one received byte per beat; the result channel gives
// exactly one result beat for every input beat, in order.
// A frame is two start bytes, a length byte, that many payload bytes and a
// big-endian CRC-16 (reflected polynomial 0xA001, initial value 0xFFFF).
// Inside a frame an escape byte makes the next byte literal, and an unescaped
// start byte aborts the frame and begins a new hunt.
// Each payload byte yields status 1 with its index; the low CRC byte yields
// status 2 (good) or 3 (CRC error) with the frame id and length; all other
// bytes yield status 0 with all other fields zero.
// A byte is held in an input register, then the frame state and the result
// register are updated in one step from it; one byte is taken in every cycle
// while the result channel is not stalled.
// When the receiver stalls, the result register holds its beat and the input
// register holds one more byte; in_ready falls once both are full.
// Synchronous reset empties both registers, returns the frame state to the
// hunt and restores start byte 0xEE and escape byte 0x30.
// The cfg port writes start_byte (index 0) and escape_byte (index 1); the user
// must write it only while no beat is in flight; the block does not enforce it.
`default_nettype none

module escaped_frame_receiver_crc16 (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      out_status,
  output logic [7:0]      out_data_byte,
  output logic [7:0]      out_data_index,
  output logic [7:0]      out_frame_id,
  output logic [7:0]      out_frame_length,
  input  wire logic       cfg_we,
  input  wire logic [0:0] cfg_index,
  input  wire logic [7:0] cfg_wdata
);
  import efrc16_pkg::*;

  logic [7:0]  start_val_r;
  logic [7:0]  escape_val_r;

  logic        in_vld_r;
  logic [7:0]  in_byte_r;

  phase_t      phase_r, phase_nxt;
  phase_t      resume_r, resume_nxt;
  logic [7:0]  pos_r, pos_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  crch_r, crch_nxt;
  logic [7:0]  first_r, first_nxt;

  logic        out_vld_r;
  logic [1:0]  status_r, status_nxt;
  logic [7:0]  dbyte_r, dbyte_nxt;
  logic [7:0]  didx_r, didx_nxt;
  logic [7:0]  fid_r, fid_nxt;
  logic [7:0]  flen_r, flen_nxt;

  logic        out_load;
  logic        adv;
  logic        in_frame;
  logic        is_start;
  logic        esc_take;
  phase_t      eff_phase;
  logic [7:0]  pos_inc;

  assign out_load = !out_vld_r || out_ready;
  assign adv      = in_vld_r && out_load;
  assign in_ready = !in_vld_r || out_load;

  assign out_valid        = out_vld_r;
  assign out_status       = status_r;
  assign out_data_byte    = dbyte_r;
  assign out_data_index   = didx_r;
  assign out_frame_id     = fid_r;
  assign out_frame_length = flen_r;

  assign is_start = (in_byte_r == start_val_r);
  assign in_frame = (phase_r == PH_LEN) || (phase_r == PH_DATA) ||
                    (phase_r == PH_CRCH) || (phase_r == PH_CRCL);
  assign esc_take = in_frame && (in_byte_r == escape_val_r);
  assign pos_inc  = pos_r + 8'd1;

  always_comb begin
    if (phase_r == PH_ESC) begin
      eff_phase = resume_r;
    end else if (in_frame && is_start) begin
      eff_phase = PH_IDLE;
    end else begin
      eff_phase = phase_r;
    end
  end

  // Next frame state.
  always_comb begin
    phase_nxt  = phase_r;
    resume_nxt = resume_r;
    pos_nxt    = pos_r;
    len_nxt    = len_r;
    crc_nxt    = crc_r;
    crch_nxt   = crch_r;
    first_nxt  = first_r;
    if (in_frame && is_start) begin
      resume_nxt = PH_IDLE;
    end
    if (esc_take) begin
      resume_nxt = eff_phase;
      phase_nxt  = PH_ESC;
    end else begin
      unique case (eff_phase)
        PH_IDLE: begin
          phase_nxt = is_start ? PH_START : PH_IDLE;
        end
        PH_START: begin
          phase_nxt = is_start ? PH_LEN : PH_IDLE;
        end
        PH_LEN: begin
          len_nxt   = in_byte_r;
          pos_nxt   = 8'd0;
          crc_nxt   = CRC_INIT;
          first_nxt = 8'd0;
          phase_nxt = (in_byte_r == 8'd0) ? PH_CRCH : PH_DATA;
        end
        PH_DATA: begin
          if (pos_r == 8'd0) begin
            first_nxt = in_byte_r;
          end
          crc_nxt   = crc16_step(crc_r, in_byte_r);
          pos_nxt   = pos_inc;
          phase_nxt = (pos_inc == len_r) ? PH_CRCH : PH_DATA;
        end
        PH_CRCH: begin
          crch_nxt  = in_byte_r;
          phase_nxt = PH_CRCL;
        end
        PH_CRCL: begin
          phase_nxt = PH_IDLE;
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  // Result for the byte in the input register.
  always_comb begin
    status_nxt = ST_NONE;
    dbyte_nxt  = 8'd0;
    didx_nxt   = 8'd0;
    fid_nxt    = 8'd0;
    flen_nxt   = 8'd0;
    if (!esc_take) begin
      unique case (eff_phase)
        PH_DATA: begin
          status_nxt = ST_DATA;
          dbyte_nxt  = in_byte_r;
          didx_nxt   = pos_r;
        end
        PH_CRCL: begin
          status_nxt = ({crch_r, in_byte_r} == crc_r) ? ST_GOOD : ST_BAD;
          fid_nxt    = first_r;
          flen_nxt   = len_r;
        end
        default: begin
          status_nxt = ST_NONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_val_r  <= START_BYTE_RST;
      escape_val_r <= ESCAPE_BYTE_RST;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_START_BYTE: begin
            start_val_r  <= cfg_wdata;
          end
          CFG_ESCAPE_BYTE: begin
            escape_val_r <= cfg_wdata;
          end
          default: begin
            escape_val_r <= escape_val_r;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_vld_r <= 1'b1;
    end else if (adv) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      resume_r <= PH_IDLE;
      pos_r    <= 8'd0;
      len_r    <= 8'd0;
      crc_r    <= CRC_INIT;
      crch_r   <= 8'd0;
      first_r  <= 8'd0;
    end else if (adv) begin
      phase_r  <= phase_nxt;
      resume_r <= resume_nxt;
      pos_r    <= pos_nxt;
      len_r    <= len_nxt;
      crc_r    <= crc_nxt;
      crch_r   <= crch_nxt;
      first_r  <= first_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= adv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      status_r <= status_nxt;
      dbyte_r  <= dbyte_nxt;
      didx_r   <= didx_nxt;
      fid_r    <= fid_nxt;
      flen_r   <= flen_nxt;
    end
  end

endmodule

`default_nettype wire
